FILE: rtl/core/ps2cc_pkg.sv
// Shared types and constants for the PS/2 controller command block.
// Used by every module in rtl/core; no dependencies.
package ps2cc_pkg;

  typedef enum logic [2:0] {
    REQ_RD_DATA   = 3'd0,
    REQ_RD_STATUS = 3'd1,
    REQ_WR_DATA   = 3'd2,
    REQ_WR_CMD    = 3'd3,
    REQ_DEV_BYTE  = 3'd4
  } req_e;

  // Data write kind armed by an earlier command
  typedef enum logic [2:0] {
    PW_NONE  = 3'd0,
    PW_CFG   = 3'd1,
    PW_SEND2 = 3'd2,
    PW_INJ1  = 3'd3,
    PW_INJ2  = 3'd4
  } pw_e;

  localparam logic [7:0] CMD_READ_CFG  = 8'h20;
  localparam logic [7:0] CMD_WRITE_CFG = 8'h60;
  localparam logic [7:0] CMD_DIS_P2    = 8'ha7;
  localparam logic [7:0] CMD_EN_P2     = 8'ha8;
  localparam logic [7:0] CMD_TEST_P2   = 8'ha9;
  localparam logic [7:0] CMD_SELF_TEST = 8'haa;
  localparam logic [7:0] CMD_TEST_P1   = 8'hab;
  localparam logic [7:0] CMD_DIS_P1    = 8'had;
  localparam logic [7:0] CMD_EN_P1     = 8'hae;
  localparam logic [7:0] CMD_INJ_P1    = 8'hd2;
  localparam logic [7:0] CMD_INJ_P2    = 8'hd3;
  localparam logic [7:0] CMD_SEND_P2   = 8'hd4;

  localparam logic [7:0] SELF_TEST_OK  = 8'h55;
  localparam logic [7:0] PORT_TEST_OK  = 8'h00;
  localparam logic [7:0] CFG_RESET     = 8'h30;

  // Config byte bit positions
  localparam int unsigned CfgIrq1Bit   = 0;
  localparam int unsigned CfgIrq2Bit   = 1;
  localparam int unsigned CfgSysBit    = 2;
  localparam int unsigned CfgClkDis1   = 4;
  localparam int unsigned CfgClkDis2   = 5;

  // APB register map
  localparam int unsigned PaddrW       = 3;
  localparam logic        REG_PORT2_PRESENT = 1'b0;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] wr_data;
    logic       src_port;
  } ps2cc_in_t;

  typedef struct packed {
    logic [7:0] rd_data;
    logic       to_device_valid;
    logic       to_device_port;
    logic [7:0] to_device_byte;
    logic       irq_port1;
    logic       irq_port2;
  } ps2cc_out_t;

endpackage

FILE: rtl/core/ps2_controller_command_regs.sv
// Controller side of an 8042-style PS/2 interface. Each request (bus read or
// write, or a byte from a device) yields exactly one response. One request is
// taken every cycle while in_stall_o is low; each response is then loaded
// into the response register by the single decode step behind the input
// register. A stalled response holds the input register and then the input.
// Config writes (port2_present at addresses 0 to 3) go through the APB port.
module ps2_controller_command_regs import ps2cc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ps2cc_in_t         in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ps2cc_out_t        out_rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic       in_valid_q;
  ps2cc_in_t  in_req_q;
  logic       out_valid_q;
  ps2cc_out_t out_rsp_q;
  ps2cc_out_t rsp;
  logic       fire;
  logic       port2_present;

  ps2cc_apb_regs u_regs (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .port2_present_o (port2_present)
  );

  ps2cc_engine u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (fire),
    .req_i           (in_req_q),
    .port2_present_i (port2_present),
    .rsp_o           (rsp)
  );

  // request moves into the response register when that slot is free
  assign fire       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (!out_valid_q || !out_stall_i) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_req_q <= in_req_i;
    end
    if (fire) begin
      out_rsp_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

FILE: rtl/core/ps2cc_apb_regs.sv
// APB-style configuration register: holds port2_present.
// Depends on ps2cc_pkg.
module ps2cc_apb_regs import ps2cc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic              port2_present_o
);

  logic port2_present_q, port2_present_d;
  logic hit;

  assign pready = 1'b1;
  assign hit    = (paddr[2] == REG_PORT2_PRESENT);

  always_comb begin
    port2_present_d = port2_present_q;
    if (psel && penable && pwrite && hit) begin
      port2_present_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port2_present_q <= 1'b1;
    end else begin
      port2_present_q <= port2_present_d;
    end
  end

  assign prdata          = hit ? {31'd0, port2_present_q} : 32'd0;
  assign port2_present_o = port2_present_q;

endmodule

FILE: rtl/core/ps2cc_engine.sv
// Controller state (config byte, output buffer, flags, pending write) and
// the per-request decode. Depends on ps2cc_pkg.
module ps2cc_engine import ps2cc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  ps2cc_in_t  req_i,
  input  logic       port2_present_i,
  output ps2cc_out_t rsp_o
);

  logic [7:0] cfg_q, cfg_d;
  logic [7:0] obuf_q, obuf_d;
  logic       full_q, full_d;
  logic       cmd_q, cmd_d;
  pw_e        pw_q, pw_d;

  logic       clk_on;
  logic       dev_ok;

  always_comb begin
    clk_on = req_i.src_port ? !cfg_q[CfgClkDis2] : !cfg_q[CfgClkDis1];
    dev_ok = clk_on && (!req_i.src_port || port2_present_i) && !full_q;
  end

  always_comb begin
    cfg_d  = cfg_q;
    obuf_d = obuf_q;
    full_d = full_q;
    cmd_d  = cmd_q;
    pw_d   = pw_q;
    rsp_o  = '0;

    unique case (req_i.req_type)
      REQ_RD_DATA: begin
        rsp_o.rd_data = obuf_q;
        full_d        = 1'b0;
      end
      REQ_RD_STATUS: begin
        rsp_o.rd_data = {4'd0, cmd_q, cfg_q[CfgSysBit], 1'b0, full_q};
      end
      REQ_WR_DATA: begin
        cmd_d = 1'b0;
        pw_d  = PW_NONE;
        unique case (pw_q)
          PW_CFG: cfg_d = req_i.wr_data;
          PW_SEND2: begin
            rsp_o.to_device_valid = 1'b1;
            rsp_o.to_device_port  = 1'b1;
            rsp_o.to_device_byte  = req_i.wr_data;
          end
          PW_INJ1: begin
            obuf_d          = req_i.wr_data;
            full_d          = 1'b1;
            rsp_o.irq_port1 = cfg_q[CfgIrq1Bit];
          end
          PW_INJ2: begin
            obuf_d          = req_i.wr_data;
            full_d          = 1'b1;
            rsp_o.irq_port2 = cfg_q[CfgIrq2Bit];
          end
          default: begin
            // nothing armed: plain byte to port one
            rsp_o.to_device_valid = 1'b1;
            rsp_o.to_device_byte  = req_i.wr_data;
          end
        endcase
      end
      REQ_WR_CMD: begin
        cmd_d = 1'b1;
        pw_d  = PW_NONE;
        unique case (req_i.wr_data)
          CMD_READ_CFG: begin
            obuf_d = cfg_q;
            full_d = 1'b1;
          end
          CMD_WRITE_CFG: pw_d = PW_CFG;
          CMD_DIS_P2:    cfg_d[CfgClkDis2] = 1'b1;
          CMD_EN_P2: begin
            if (port2_present_i) begin
              cfg_d[CfgClkDis2] = 1'b0;
            end
          end
          CMD_TEST_P2, CMD_TEST_P1: begin
            obuf_d = PORT_TEST_OK;
            full_d = 1'b1;
          end
          CMD_SELF_TEST: begin
            obuf_d = SELF_TEST_OK;
            full_d = 1'b1;
          end
          CMD_DIS_P1:    cfg_d[CfgClkDis1] = 1'b1;
          CMD_EN_P1:     cfg_d[CfgClkDis1] = 1'b0;
          CMD_INJ_P1:    pw_d = PW_INJ1;
          CMD_INJ_P2:    pw_d = PW_INJ2;
          CMD_SEND_P2:   pw_d = PW_SEND2;
          default: ;
        endcase
      end
      REQ_DEV_BYTE: begin
        if (dev_ok) begin
          obuf_d          = req_i.wr_data;
          full_d          = 1'b1;
          rsp_o.irq_port1 = !req_i.src_port && cfg_q[CfgIrq1Bit];
          rsp_o.irq_port2 = req_i.src_port && cfg_q[CfgIrq2Bit];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q  <= CFG_RESET;
      obuf_q <= 8'd0;
      full_q <= 1'b0;
      cmd_q  <= 1'b0;
      pw_q   <= PW_NONE;
    end else if (fire_i) begin
      cfg_q  <= cfg_d;
      obuf_q <= obuf_d;
      full_q <= full_d;
      cmd_q  <= cmd_d;
      pw_q   <= pw_d;
    end
  end

endmodule

FILE: rtl/core/ps2cc_checker.sv
// Port-level checks for ps2_controller_command_regs, bound to the top level.
// Depends on ps2cc_pkg.
module ps2cc_checker import ps2cc_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input ps2cc_out_t out_rsp_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled response changed");

  a_idle_device_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.to_device_valid |->
      !out_rsp_o.to_device_port && (out_rsp_o.to_device_byte == 8'd0))
    else $error("device fields set without a send");

  a_send_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.to_device_valid |->
      !out_rsp_o.irq_port1 && !out_rsp_o.irq_port2 && (out_rsp_o.rd_data == 8'd0))
    else $error("send response carries other fields");

  a_irq_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_rsp_o.irq_port1 && out_rsp_o.irq_port2))
    else $error("both port interrupts in one response");

endmodule

bind ps2_controller_command_regs ps2cc_checker u_ps2cc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);

FILE: sim/tb_ps2_controller_command_regs.sv
// Self-checking testbench for ps2_controller_command_regs: random bus and device
// requests with bursty valid and receiver stalls, checked against an in-bench model.
// Depends on ps2cc_pkg and the block's RTL only.
module tb_ps2_controller_command_regs;
  import ps2cc_pkg::*;

  localparam int unsigned StsFullBit = 0;
  localparam int unsigned StsCmdBit  = 3;
  localparam logic [PaddrW-1:0] AddrPort2Present = {REG_PORT2_PRESENT, 2'b00};
  localparam logic [PaddrW-1:0] AddrUnmapped     = 3'd4;
  localparam int unsigned HoldCycles = 200;

  logic              clk_i;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  ps2cc_in_t         in_req_i    = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  ps2cc_out_t        out_rsp_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [PaddrW-1:0] paddr       = '0;
  logic [31:0]       pwdata      = '0;
  logic [31:0]       prdata;
  logic              pready;

  ps2_controller_command_regs i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Controller state as the block should hold it
  logic [7:0] cfg_byte  = CFG_RESET;
  logic [7:0] obuf      = '0;
  logic       ofull     = 1'b0;
  logic       last_cmd  = 1'b0;
  pw_e        pend      = PW_NONE;
  logic       p2_present = 1'b1;

  ps2cc_in_t  req_q[$];
  ps2cc_out_t rsp_q[$];
  int         n_counted = 0;
  int         n_fail = 0;
  int         n_rsp = 0;

  int         gap_left = 0;
  int         burst_left = 0;
  int         stall_mode = 0;
  int         mode_left = 0;
  int         hold_left = 0;
  int         holds_done = 0;
  ps2cc_out_t rsp_exp;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic void note_fail(string msg);
    n_fail++;
    if (n_fail <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic void load_obuf(logic [7:0] b);
    obuf  = b;
    ofull = 1'b1;
  endfunction

  function automatic ps2cc_out_t ps2_predict(ps2cc_in_t rq);
    ps2cc_out_t r;
    logic       clk_on;
    logic       exists;
    r = '0;
    case (rq.req_type)
      REQ_RD_DATA: begin
        r.rd_data = obuf;
        ofull = 1'b0;
      end
      REQ_RD_STATUS: begin
        r.rd_data[StsFullBit] = ofull;
        r.rd_data[CfgSysBit]  = cfg_byte[CfgSysBit];
        r.rd_data[StsCmdBit]  = last_cmd;
      end
      REQ_WR_DATA: begin
        last_cmd = 1'b0;
        case (pend)
          PW_CFG: cfg_byte = rq.wr_data;
          PW_SEND2: begin
            r.to_device_valid = 1'b1;
            r.to_device_port  = 1'b1;
            r.to_device_byte  = rq.wr_data;
          end
          PW_INJ1: begin
            load_obuf(rq.wr_data);
            r.irq_port1 = cfg_byte[CfgIrq1Bit];
          end
          PW_INJ2: begin
            load_obuf(rq.wr_data);
            r.irq_port2 = cfg_byte[CfgIrq2Bit];
          end
          default: begin
            // nothing armed: byte goes to port one
            r.to_device_valid = 1'b1;
            r.to_device_byte  = rq.wr_data;
          end
        endcase
        pend = PW_NONE;
      end
      REQ_WR_CMD: begin
        last_cmd = 1'b1;
        pend     = PW_NONE;
        case (rq.wr_data)
          CMD_READ_CFG:  load_obuf(cfg_byte);
          CMD_WRITE_CFG: pend = PW_CFG;
          CMD_DIS_P2:    cfg_byte[CfgClkDis2] = 1'b1;
          CMD_EN_P2:     if (p2_present) cfg_byte[CfgClkDis2] = 1'b0;
          CMD_TEST_P2:   load_obuf(PORT_TEST_OK);
          CMD_SELF_TEST: load_obuf(SELF_TEST_OK);
          CMD_TEST_P1:   load_obuf(PORT_TEST_OK);
          CMD_DIS_P1:    cfg_byte[CfgClkDis1] = 1'b1;
          CMD_EN_P1:     cfg_byte[CfgClkDis1] = 1'b0;
          CMD_INJ_P1:    pend = PW_INJ1;
          CMD_INJ_P2:    pend = PW_INJ2;
          CMD_SEND_P2:   pend = PW_SEND2;
          default: ;
        endcase
      end
      REQ_DEV_BYTE: begin
        clk_on = !cfg_byte[rq.src_port ? CfgClkDis2 : CfgClkDis1];
        exists = !rq.src_port || p2_present;
        if (clk_on && exists && !ofull) begin
          load_obuf(rq.wr_data);
          if (rq.src_port) r.irq_port2 = cfg_byte[CfgIrq2Bit];
          else r.irq_port1 = cfg_byte[CfgIrq1Bit];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Request driver: bursts of random length separated by random gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        rsp_q.push_back(ps2_predict(in_req_i));
        void'(req_q.pop_front());
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (req_q.size() > 0) begin
          in_valid_i <= 1'b1;
          in_req_i   <= req_q[0];
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            if ($urandom_range(0, 9) < 3) gap_left = 0;
            else if ($urandom_range(0, 19) == 0) gap_left = $urandom_range(5, 15);
            else gap_left = $urandom_range(1, 4);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Response monitor and receiver stall pattern
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        n_rsp++;
        if (rsp_q.size() == 0) begin
          note_fail($sformatf("response %h with none expected", out_rsp_o));
        end else begin
          rsp_exp = rsp_q.pop_front();
          if (out_rsp_o.rd_data !== rsp_exp.rd_data)
            note_fail($sformatf("rd_data expected %h got %h",
                                rsp_exp.rd_data, out_rsp_o.rd_data));
          if (out_rsp_o.to_device_valid !== rsp_exp.to_device_valid)
            note_fail($sformatf("to_device_valid expected %b got %b",
                                rsp_exp.to_device_valid, out_rsp_o.to_device_valid));
          if (out_rsp_o.to_device_port !== rsp_exp.to_device_port)
            note_fail($sformatf("to_device_port expected %b got %b",
                                rsp_exp.to_device_port, out_rsp_o.to_device_port));
          if (out_rsp_o.to_device_byte !== rsp_exp.to_device_byte)
            note_fail($sformatf("to_device_byte expected %h got %h",
                                rsp_exp.to_device_byte, out_rsp_o.to_device_byte));
          if (out_rsp_o.irq_port1 !== rsp_exp.irq_port1)
            note_fail($sformatf("irq_port1 expected %b got %b",
                                rsp_exp.irq_port1, out_rsp_o.irq_port1));
          if (out_rsp_o.irq_port2 !== rsp_exp.irq_port2)
            note_fail($sformatf("irq_port2 expected %b got %b",
                                rsp_exp.irq_port2, out_rsp_o.irq_port2));
        end
      end
      // long hold-offs so the block backs up into its input
      if (hold_left == 0 && ((holds_done == 0 && n_rsp >= 400) ||
                             (holds_done == 1 && n_rsp >= 1300))) begin
        hold_left = HoldCycles;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 2);
          mode_left  = $urandom_range(10, 80);
        end
        mode_left--;
        case (stall_mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 99) < 30);
          default: out_stall_i <= ($urandom_range(0, 99) < 75);
        endcase
      end
    end
  end

  function automatic logic rnd_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic void push_item(logic [2:0] rt, logic [7:0] d, logic p);
    ps2cc_in_t it;
    it.req_type = rt;
    it.wr_data  = d;
    it.src_port = p;
    req_q.push_back(it);
    if (rt <= REQ_DEV_BYTE) n_counted++;
  endfunction

  function automatic logic [7:0] any_cmd();
    case ($urandom_range(0, 12))
      0:  return CMD_READ_CFG;
      1:  return CMD_WRITE_CFG;
      2:  return CMD_DIS_P2;
      3:  return CMD_EN_P2;
      4:  return CMD_TEST_P2;
      5:  return CMD_SELF_TEST;
      6:  return CMD_TEST_P1;
      7:  return CMD_DIS_P1;
      8:  return CMD_EN_P1;
      9:  return CMD_INJ_P1;
      10: return CMD_INJ_P2;
      11: return CMD_SEND_P2;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] arming_cmd();
    case ($urandom_range(0, 3))
      0:       return CMD_WRITE_CFG;
      1:       return CMD_INJ_P1;
      2:       return CMD_INJ_P2;
      default: return CMD_SEND_P2;
    endcase
  endfunction

  // One short request sequence; mostly well formed, some broken or noise
  task automatic gen_seq();
    int         kind;
    int         n;
    logic [7:0] v;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      v = 8'($urandom);
      if ($urandom_range(0, 3) != 0) v[CfgClkDis2:CfgClkDis1] = 2'b00;
      push_item(REQ_WR_CMD, CMD_WRITE_CFG, rnd_bit());
      if ($urandom_range(0, 4) == 0) push_item(REQ_RD_STATUS, 8'($urandom), rnd_bit());
      push_item(REQ_WR_DATA, v, rnd_bit());
    end else if (kind < 27) begin
      push_item(REQ_WR_CMD, rnd_bit() ? CMD_INJ_P2 : CMD_INJ_P1, rnd_bit());
      push_item(REQ_WR_DATA, 8'($urandom), rnd_bit());
      if (rnd_bit()) push_item(REQ_RD_DATA, 8'($urandom), rnd_bit());
    end else if (kind < 35) begin
      push_item(REQ_WR_CMD, CMD_SEND_P2, rnd_bit());
      push_item(REQ_WR_DATA, 8'($urandom), rnd_bit());
    end else if (kind < 42) begin
      case ($urandom_range(0, 9))
        0, 1:    push_item(REQ_WR_CMD, CMD_DIS_P1, rnd_bit());
        2:       push_item(REQ_WR_CMD, CMD_DIS_P2, rnd_bit());
        3, 4, 5: push_item(REQ_WR_CMD, CMD_EN_P1, rnd_bit());
        default: push_item(REQ_WR_CMD, CMD_EN_P2, rnd_bit());
      endcase
    end else if (kind < 62) begin
      n = $urandom_range(1, 3);
      repeat (n) push_item(REQ_DEV_BYTE, 8'($urandom), rnd_bit());
      if ($urandom_range(0, 3) == 0) push_item(REQ_RD_STATUS, 8'($urandom), rnd_bit());
      if ($urandom_range(0, 9) < 6) push_item(REQ_RD_DATA, 8'($urandom), rnd_bit());
    end else if (kind < 70) begin
      case ($urandom_range(0, 3))
        0:       push_item(REQ_WR_CMD, CMD_READ_CFG, rnd_bit());
        1:       push_item(REQ_WR_CMD, CMD_TEST_P2, rnd_bit());
        2:       push_item(REQ_WR_CMD, CMD_SELF_TEST, rnd_bit());
        default: push_item(REQ_WR_CMD, CMD_TEST_P1, rnd_bit());
      endcase
      push_item(REQ_RD_DATA, 8'($urandom), rnd_bit());
    end else if (kind < 78) begin
      push_item(rnd_bit() ? REQ_RD_STATUS : REQ_RD_DATA, 8'($urandom), rnd_bit());
    end else if (kind < 84) begin
      push_item(REQ_WR_DATA, 8'($urandom), rnd_bit());
    end else if (kind < 92) begin
      // armed write interrupted by another command or an unrelated request
      push_item(REQ_WR_CMD, arming_cmd(), rnd_bit());
      if (rnd_bit()) push_item(REQ_WR_CMD, any_cmd(), rnd_bit());
      else push_item(3'($urandom_range(0, 1) ? REQ_DEV_BYTE : REQ_RD_DATA),
                     8'($urandom), rnd_bit());
      push_item(REQ_WR_DATA, 8'($urandom), rnd_bit());
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) push_item(3'($urandom_range(0, 7)), 8'($urandom), rnd_bit());
      if (rnd_bit()) push_item(REQ_WR_CMD, any_cmd(), rnd_bit());
    end
  endtask

  task automatic wait_idle();
    while (req_q.size() != 0 || in_valid_i || rsp_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_random(int count);
    int target;
    target = n_counted + count;
    while (n_counted < target) gen_seq();
    wait_idle();
  endtask

  task automatic apb_write(logic [PaddrW-1:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == AddrPort2Present) p2_present = data[0];
  endtask

  task automatic apb_check(logic [PaddrW-1:0] addr, logic [31:0] want);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want)
      note_fail($sformatf("register read at %0d expected %h got %h", addr, want, prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset state, answers, enables, injections, sends, cancels
    push_item(REQ_RD_STATUS, 8'h00, 1'b0);
    push_item(REQ_RD_DATA, 8'hff, 1'b1);            // empty buffer, stale value
    push_item(REQ_DEV_BYTE, 8'h3c, 1'b0);           // clock off: dropped
    push_item(REQ_WR_CMD, CMD_SELF_TEST, 1'b0);
    push_item(REQ_RD_STATUS, 8'h00, 1'b0);
    push_item(REQ_RD_DATA, 8'h00, 1'b0);
    push_item(REQ_WR_CMD, CMD_EN_P1, 1'b0);
    push_item(REQ_WR_CMD, CMD_EN_P2, 1'b0);
    push_item(REQ_WR_CMD, CMD_WRITE_CFG, 1'b0);
    push_item(REQ_WR_DATA, 8'hc7, 1'b0);            // irqs on, system flag, clocks on
    push_item(REQ_WR_CMD, CMD_READ_CFG, 1'b0);
    push_item(REQ_RD_DATA, 8'h00, 1'b0);
    push_item(REQ_DEV_BYTE, 8'hff, 1'b0);
    push_item(REQ_DEV_BYTE, 8'h00, 1'b1);           // buffer full: dropped
    push_item(REQ_RD_DATA, 8'h00, 1'b0);
    push_item(REQ_DEV_BYTE, 8'ha5, 1'b1);
    push_item(REQ_WR_CMD, CMD_TEST_P2, 1'b0);       // answer overwrites full buffer
    push_item(REQ_WR_CMD, CMD_TEST_P1, 1'b1);
    push_item(REQ_WR_CMD, CMD_INJ_P1, 1'b0);
    push_item(REQ_WR_DATA, 8'h80, 1'b0);
    push_item(REQ_WR_CMD, CMD_INJ_P2, 1'b0);
    push_item(REQ_WR_DATA, 8'h01, 1'b0);
    push_item(REQ_WR_CMD, CMD_SEND_P2, 1'b0);
    push_item(REQ_WR_DATA, 8'h5a, 1'b0);
    push_item(REQ_WR_DATA, 8'hff, 1'b0);            // nothing armed: to port one
    push_item(REQ_WR_CMD, 8'hd0, 1'b0);             // unknown command
    push_item(3'd7, 8'hff, 1'b1);                   // ignored request type
    push_item(REQ_WR_CMD, CMD_WRITE_CFG, 1'b0);
    push_item(REQ_WR_CMD, CMD_DIS_P1, 1'b0);        // cancels the armed write
    push_item(REQ_WR_DATA, 8'h00, 1'b0);
    wait_idle();

    apb_write(AddrPort2Present, 32'd1);
    apb_check(AddrPort2Present, 32'd1);
    run_random(500);

    // port two absent
    apb_write(AddrPort2Present, 32'd0);
    apb_check(AddrPort2Present, 32'd0);
    push_item(REQ_WR_CMD, CMD_WRITE_CFG, 1'b0);
    push_item(REQ_WR_DATA, 8'h03, 1'b0);
    push_item(REQ_RD_DATA, 8'h00, 1'b0);
    push_item(REQ_DEV_BYTE, 8'h77, 1'b1);           // absent port: dropped
    push_item(REQ_WR_CMD, CMD_DIS_P2, 1'b0);
    push_item(REQ_WR_CMD, CMD_EN_P2, 1'b0);         // no effect without port two
    push_item(REQ_WR_CMD, CMD_READ_CFG, 1'b0);
    push_item(REQ_RD_DATA, 8'h00, 1'b0);
    run_random(400);

    // write to an unmapped index must leave the register alone
    apb_write(AddrUnmapped, 32'hffff_ffff);
    apb_check(AddrPort2Present, 32'd0);
    run_random(250);

    apb_write(AddrPort2Present, 32'd1);
    run_random(450);

    apb_write(AddrPort2Present, 32'd0);
    run_random(250);

    repeat (8) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(8 * 400000);
    $display("status: fail");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/ps2cc_pkg.sv
rtl/core/ps2cc_apb_regs.sv
rtl/core/ps2cc_engine.sv
rtl/core/ps2_controller_command_regs.sv
rtl/core/ps2cc_checker.sv
sim/tb_ps2_controller_command_regs.sv
